/* sv/ragg_pkg.sv */
// ----------------------------------------------------------------------------
// Running aggregate package
// Shared widths, codes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package ragg_pkg;

  localparam int COUNT_BITS   = 24;
  localparam int SAMPLE_BITS  = 24;
  localparam int VAL_BITS     = 48;
  localparam int DIV_CNT_BITS = $clog2(VAL_BITS);

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } ragg_act_e;

  typedef enum logic [2:0] {
    MODE_MIN   = 3'd0,
    MODE_MAX   = 3'd1,
    MODE_SUM   = 3'd2,
    MODE_MEAN  = 3'd3,
    MODE_COUNT = 3'd4
  } ragg_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_LOAD = 3'b100
  } ragg_state_e;

  typedef struct packed {
    logic add;
    logic clr;
    logic div_start;
    logic div_step;
    logic load_direct;
    logic load_div;
  } ragg_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic count_mode;
  } ragg_sts_t;

endpackage

/* sv/ragg_ctrl.sv */
// ----------------------------------------------------------------------------
// Running aggregate controller
// Handshake control, one-hot sequencer for the mean divide and result valid.
// ----------------------------------------------------------------------------
module ragg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ragg_pkg::ragg_sts_t sts_i,
  output ragg_pkg::ragg_cmd_t cmd_o
);

  ragg_pkg::ragg_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;
  logic                  in_fire;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ragg_pkg::ST_IDLE) &&
                       ((action_i != ragg_pkg::ACT_READ) || out_free);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ragg_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (action_i)
            ragg_pkg::ACT_ADD:   cmd_o.add = 1'b1;
            ragg_pkg::ACT_CLEAR: cmd_o.clr = 1'b1;
            ragg_pkg::ACT_READ: begin
              if (sts_i.need_div) begin
                cmd_o.div_start = 1'b1;
                state_d         = ragg_pkg::ST_DIV;
              end else begin
                cmd_o.load_direct = 1'b1;
                out_valid_d       = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ragg_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ragg_pkg::ST_LOAD;
        end
      end
      ragg_pkg::ST_LOAD: begin
        if (out_free) begin
          cmd_o.load_div = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ragg_pkg::ST_IDLE;
        end
      end
      default: state_d = ragg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ragg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* sv/ragg_dp.sv */
// ----------------------------------------------------------------------------
// Running aggregate datapath
// Mode register, running value and count, bit-serial divider, result register.
// ----------------------------------------------------------------------------
module ragg_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    mode_we_i,
  input  logic [2:0]                              mode_wdata_i,
  input  logic signed [ragg_pkg::SAMPLE_BITS-1:0] sample_value_i,
  input  ragg_pkg::ragg_cmd_t                     cmd_i,
  output ragg_pkg::ragg_sts_t                     sts_o,
  output logic signed [ragg_pkg::VAL_BITS-1:0]    result_value_o,
  output logic                                    empty_res_o
);

  localparam int VB = ragg_pkg::VAL_BITS;
  localparam int CB = ragg_pkg::COUNT_BITS;
  localparam int SB = ragg_pkg::SAMPLE_BITS;
  localparam int DB = ragg_pkg::DIV_CNT_BITS;
  localparam logic signed [VB-1:0] SUM_MAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] SUM_MIN = {1'b1, {(VB-1){1'b0}}};

  logic [2:0]           mode_q;
  logic signed [VB-1:0] run_q, run_d;
  logic [CB-1:0]        cnt_q, cnt_d;
  logic [VB-1:0]        dvd_q, dvd_d;
  logic [CB-1:0]        rem_q, rem_d;
  logic [DB-1:0]        step_q, step_d;
  logic                 neg_q, neg_d;
  logic signed [VB-1:0] res_q, res_d;
  logic                 empty_q, empty_d;

  logic signed [VB-1:0] samp_ext;
  logic signed [VB:0]   sum_full;
  logic signed [VB-1:0] sum_sat;
  logic                 cnt_empty;
  logic [VB-1:0]        run_abs;
  logic [CB:0]          rem_sh;
  logic                 rem_ge;
  logic [CB:0]          rem_sub;

  assign samp_ext  = {{(VB-SB){sample_value_i[SB-1]}}, sample_value_i};
  assign sum_full  = {run_q[VB-1], run_q} + {samp_ext[VB-1], samp_ext};
  assign sum_sat   = (sum_full[VB] != sum_full[VB-1]) ? (sum_full[VB] ? SUM_MIN : SUM_MAX)
                                                      : sum_full[VB-1:0];
  assign cnt_empty = (cnt_q == '0);
  assign run_abs   = run_q[VB-1] ? (-run_q) : run_q;
  assign rem_sh    = {rem_q, dvd_q[VB-1]};
  assign rem_ge    = rem_sh >= {1'b0, cnt_q};
  assign rem_sub   = rem_sh - {1'b0, cnt_q};

  assign sts_o.need_div   = (mode_q == ragg_pkg::MODE_MEAN) && !cnt_empty;
  assign sts_o.div_last   = (step_q == DB'(VB-1));
  assign sts_o.count_mode = (mode_q == ragg_pkg::MODE_COUNT);

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    if (cmd_i.clr) begin
      run_d = '0;
      cnt_d = '0;
    end else if (cmd_i.add) begin
      case (mode_q)
        ragg_pkg::MODE_MIN: begin
          if (cnt_empty || (samp_ext < run_q)) run_d = samp_ext;
        end
        ragg_pkg::MODE_MAX: begin
          if (cnt_empty || (samp_ext > run_q)) run_d = samp_ext;
        end
        ragg_pkg::MODE_SUM, ragg_pkg::MODE_MEAN: run_d = sum_sat;
        default: ;
      endcase
      if (cnt_q != '1) cnt_d = cnt_q + CB'(1);
    end
  end

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    step_d = step_q;
    neg_d  = neg_q;
    if (cmd_i.div_start) begin
      dvd_d  = run_abs;
      rem_d  = '0;
      step_d = '0;
      neg_d  = run_q[VB-1];
    end else if (cmd_i.div_step) begin
      dvd_d  = {dvd_q[VB-2:0], rem_ge};
      rem_d  = rem_ge ? rem_sub[CB-1:0] : rem_sh[CB-1:0];
      step_d = step_q + DB'(1);
    end
  end

  always_comb begin
    res_d   = res_q;
    empty_d = empty_q;
    if (cmd_i.load_div) begin
      res_d   = neg_q ? (-dvd_q) : dvd_q;
      empty_d = 1'b0;
    end else if (cmd_i.load_direct) begin
      empty_d = cnt_empty && (mode_q != ragg_pkg::MODE_COUNT);
      case (mode_q)
        ragg_pkg::MODE_MIN, ragg_pkg::MODE_MAX, ragg_pkg::MODE_SUM: res_d = run_q;
        ragg_pkg::MODE_COUNT: res_d = {{(VB-CB){1'b0}}, cnt_q};
        default:              res_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ragg_pkg::MODE_MEAN;
      run_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (mode_we_i) mode_q <= mode_wdata_i;
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    neg_q   <= neg_d;
    res_q   <= res_d;
    empty_q <= empty_d;
  end

  assign result_value_o = res_q;
  assign empty_res_o    = empty_q;

endmodule

/* sv/running_aggregate_top.sv */
// ----------------------------------------------------------------------------
// Running aggregate top level
// Running min, max, sum, mean or count over signed Q15.8 samples.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries action_i and sample_value_i:
// add, read or clear. Only a read produces a transfer on the output channel
// (out_valid_o/out_ready_i) with result_value_o and empty_res_o.
// mode_we_i writes the aggregate kind from mode_wdata_i; the user must do so
// only while the block idles; the block does not enforce this. Adds and
// clears stream at one per cycle while no mean read runs. A read in min,
// max, sum or count mode, or of an empty mean, shows its result the cycle
// after it is taken. A mean read runs a restoring divider, one quotient bit
// a cycle, then loads the result once the output side is free; no item is
// taken meanwhile.
// The result register frees the input side: adds and clears go on while a
// result waits; a read waits only until the held result is taken.
// Reset empties the window and sets mean mode.
// ----------------------------------------------------------------------------
module running_aggregate_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [1:0]                              action_i,
  input  logic signed [ragg_pkg::SAMPLE_BITS-1:0] sample_value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [ragg_pkg::VAL_BITS-1:0]    result_value_o,
  output logic                                    empty_res_o,
  input  logic                                    mode_we_i,
  input  logic [2:0]                              mode_wdata_i
);

  ragg_pkg::ragg_cmd_t cmd;
  ragg_pkg::ragg_sts_t sts;

  ragg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ragg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_we_i      (mode_we_i),
    .mode_wdata_i   (mode_wdata_i),
    .sample_value_i (sample_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_value_o (result_value_o),
    .empty_res_o    (empty_res_o)
  );

  a_count_read_direct : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ragg_pkg::ACT_READ) && sts.count_mode
    |=> out_valid_o && !empty_res_o)
    else $error("count read did not give a non-empty result next cycle");

  a_mean_read_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ragg_pkg::ACT_READ) && sts.need_div
    |=> !in_ready_o)
    else $error("input taken while dividing");

  a_single_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.add, cmd.clr, cmd.div_start, cmd.div_step, cmd.load_direct}))
    else $error("conflicting datapath commands");

endmodule

/* dv/tb_running_aggregate_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Running aggregate testbench
// Streams add, read and clear transfers into running_aggregate_top under
// changing modes, random input gaps and output back-pressure. A local
// predictor of the running value and sample count works out every read
// result, and a checker compares each output transfer with the oldest one.
// ----------------------------------------------------------------------------
module tb_running_aggregate_top;

  localparam logic [1:0] ACT_RSVD = 2'd3;
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam int SB = ragg_pkg::SAMPLE_BITS;
  localparam int VB = ragg_pkg::VAL_BITS;
  localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam longint SUM_MAX = (64'sd1 <<< (VB - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam longint COUNT_MAX = (64'sd1 <<< ragg_pkg::COUNT_BITS) - 1;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES = 60;
  localparam int STALL_LIMIT = 20000;
  localparam int PRINT_LIMIT = 30;

  typedef struct packed {
    logic signed [VB-1:0] value;
    logic                 empty;
  } agg_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           action_i = ragg_pkg::ACT_ADD;
  logic signed [SB-1:0] sample_value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [VB-1:0] result_value_o;
  logic                 empty_res_o;
  logic                 mode_we_i = 1'b0;
  logic [2:0]           mode_wdata_i = ragg_pkg::MODE_MEAN;

  running_aggregate_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .empty_res_o    (empty_res_o),
    .mode_we_i      (mode_we_i),
    .mode_wdata_i   (mode_wdata_i)
  );

  // predictor state
  logic [2:0] agg_mode = ragg_pkg::MODE_MEAN;
  longint     run_val = 0;
  longint     sample_cnt = 0;
  agg_res_t   read_results_q[$];

  int send_idle_pct = 14;
  int recv_idle_pct = 77;
  int mismatches = 0;
  int items_sent = 0;
  int reads_checked = 0;
  int mode_writes = 0;
  int stall_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void predict_aggregate(input logic [1:0] act,
                                            input logic signed [SB-1:0] smp);
    longint   v;
    longint   acc;
    agg_res_t r;
    v = smp;
    case (act)
      ragg_pkg::ACT_ADD: begin
        case (agg_mode)
          ragg_pkg::MODE_MIN: if (sample_cnt == 0 || v < run_val) run_val = v;
          ragg_pkg::MODE_MAX: if (sample_cnt == 0 || v > run_val) run_val = v;
          ragg_pkg::MODE_SUM, ragg_pkg::MODE_MEAN: begin
            acc = run_val + v;
            if (acc > SUM_MAX) acc = SUM_MAX;
            if (acc < SUM_MIN) acc = SUM_MIN;
            run_val = acc;
          end
          default: ;
        endcase
        if (sample_cnt < COUNT_MAX) sample_cnt++;
      end
      ragg_pkg::ACT_CLEAR: begin
        sample_cnt = 0;
        run_val = 0;
      end
      ragg_pkg::ACT_READ: begin
        r.empty = (sample_cnt == 0);
        r.value = '0;
        case (agg_mode)
          ragg_pkg::MODE_MIN, ragg_pkg::MODE_MAX, ragg_pkg::MODE_SUM:
            r.value = VB'(run_val);
          ragg_pkg::MODE_MEAN: if (sample_cnt != 0) r.value = VB'(run_val / sample_cnt);
          ragg_pkg::MODE_COUNT: begin
            r.value = VB'(sample_cnt);
            r.empty = 1'b0;
          end
          default: ;
        endcase
        read_results_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic send_item(input logic [1:0] act, input logic signed [SB-1:0] smp);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    sample_value_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    predict_aggregate(act, smp);
    if (act != ACT_RSVD) items_sent++;
  endtask

  // hold the input until every read result has been taken
  task automatic drain_reads();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (read_results_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic [2:0] m);
    drain_reads();
    mode_we_i    <= 1'b1;
    mode_wdata_i <= m;
    @(negedge clk_i);
    mode_we_i <= 1'b0;
    agg_mode = m;
    mode_writes++;
  endtask

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2, 3:    return SB'($signed($urandom_range(2047)) - 1024);
      default: return SB'($urandom);
    endcase
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    agg_res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (read_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", result_value_o));
      end else begin
        exp_r = read_results_q.pop_front();
        reads_checked++;
        if (result_value_o !== exp_r.value)
          report_mismatch($sformatf("result_value %0d, want %0d", result_value_o,
                                    exp_r.value));
        if (empty_res_o !== exp_r.empty)
          report_mismatch($sformatf("empty_res %b, want %b", empty_res_o, exp_r.empty));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic test_empty_after_reset();
    send_item(ragg_pkg::ACT_READ, '0);
  endtask

  task automatic test_mean_truncation();
    send_item(ragg_pkg::ACT_ADD, SMP_MAX);
    send_item(ragg_pkg::ACT_ADD, SMP_MIN);
    send_item(ragg_pkg::ACT_READ, '0);
    send_item(ragg_pkg::ACT_ADD, SB'(-3));
    send_item(ragg_pkg::ACT_READ, '0);
  endtask

  task automatic test_mode_switch_held();
    write_mode(ragg_pkg::MODE_SUM);
    send_item(ragg_pkg::ACT_READ, '0);
    write_mode(ragg_pkg::MODE_MIN);
    send_item(ragg_pkg::ACT_READ, '0);
  endtask

  task automatic test_min_max_first_sample();
    send_item(ragg_pkg::ACT_CLEAR, '0);
    send_item(ragg_pkg::ACT_READ, '0);
    send_item(ragg_pkg::ACT_ADD, SB'(5));
    send_item(ragg_pkg::ACT_ADD, SB'(-7));
    send_item(ragg_pkg::ACT_ADD, SB'(100));
    send_item(ragg_pkg::ACT_READ, '0);
    write_mode(ragg_pkg::MODE_MAX);
    send_item(ragg_pkg::ACT_CLEAR, '0);
    send_item(ragg_pkg::ACT_ADD, SMP_MIN);
    send_item(ragg_pkg::ACT_READ, '0);
    send_item(ragg_pkg::ACT_ADD, SMP_MAX);
    send_item(ragg_pkg::ACT_READ, '0);
  endtask

  task automatic test_count_and_unused();
    write_mode(ragg_pkg::MODE_COUNT);
    send_item(ragg_pkg::ACT_READ, '0);
    send_item(ragg_pkg::ACT_CLEAR, '0);
    send_item(ragg_pkg::ACT_READ, '0);
    write_mode(MODE_RSVD7);
    send_item(ragg_pkg::ACT_ADD, SB'(1));
    send_item(ragg_pkg::ACT_READ, '0);
    send_item(ragg_pkg::ACT_CLEAR, '0);
    send_item(ragg_pkg::ACT_READ, '0);
    send_item(ACT_RSVD, SMP_MAX);
    send_item(ragg_pkg::ACT_READ, '0);
  endtask

  task automatic test_random_traffic(input int n_items);
    int         target;
    int         burst;
    int         roll;
    logic [2:0] m;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(9) < 8) m = 3'($urandom_range(ragg_pkg::MODE_COUNT, ragg_pkg::MODE_MIN));
      else m = 3'($urandom_range(MODE_RSVD7, MODE_RSVD5));
      write_mode(m);
      if ($urandom_range(1)) send_item(ragg_pkg::ACT_CLEAR, pick_sample());
      burst = $urandom_range(30, 1);
      repeat (burst) begin
        roll = $urandom_range(99);
        if (roll < 75) send_item(ragg_pkg::ACT_ADD, pick_sample());
        else if (roll < 92) send_item(ragg_pkg::ACT_READ, pick_sample());
        else if (roll < 97) send_item(ragg_pkg::ACT_CLEAR, pick_sample());
        else send_item(ACT_RSVD, pick_sample());
      end
      send_item(ragg_pkg::ACT_READ, pick_sample());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_after_reset();
    test_mean_truncation();
    test_mode_switch_held();
    test_min_max_first_sample();
    test_count_and_unused();

    test_random_traffic(330);
    drain_reads();
    send_idle_pct = 77;
    recv_idle_pct = 14;
    test_random_traffic(330);
    drain_reads();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(340);

    drain_reads();
    repeat (END_CYCLES) @(posedge clk_i);
    $display("covered %0d input transfers and %0d checked reads over %0d mode writes",
             items_sent, reads_checked, mode_writes);
    $display("modes min to unused, empty/clear/switch cases, three back-pressure mixes");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
